// ===== design/tpc_pkg.sv =====
// Package for the triangle plane classifier: side and class codes,
// configuration register indexes and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps

package tpc_pkg;

    // number of fraction bits of the Q16.16 formats
    localparam int QFRAC = 16;

    // vertices per triangle
    localparam int VERTEX_COUNT = 3;

    // width of the configuration register index
    localparam int CFG_IDX_W = 8;

    // reset value of the on-plane tolerance (about 0.001 in Q16.16)
    localparam int EPS_RESET = 66;

    // per-vertex side code
    typedef enum logic [1:0] {
        SIDE_FRONT = 2'd0,
        SIDE_BACK  = 2'd1,
        SIDE_ON    = 2'd2
    } t_side;

    // whole-triangle class code
    typedef enum logic [1:0] {
        CLASS_FRONT   = 2'd0,
        CLASS_BACK    = 2'd1,
        CLASS_ON      = 2'd2,
        CLASS_CLIPPED = 2'd3
    } t_tri_class;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X = 8'd0,
        CFG_NORMAL_Y = 8'd1,
        CFG_NORMAL_Z = 8'd2,
        CFG_OFFSET   = 8'd3,
        CFG_EPSILON  = 8'd4
    } t_cfg_idx;

    // load enables of the pipeline stages inside a vertex lane
    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_pipe_ctl;

endpackage

// ===== design/tpc_if.sv =====
// Valid/ready channel interfaces of the triangle plane classifier:
// triangle input channel and classification result channel.
// Depends on tpc_pkg for the side and class codes.
`timescale 1ns / 1ps

interface tpc_tri_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] v0_x;
    logic signed [COORD_WIDTH-1:0] v0_y;
    logic signed [COORD_WIDTH-1:0] v0_z;
    logic signed [COORD_WIDTH-1:0] v1_x;
    logic signed [COORD_WIDTH-1:0] v1_y;
    logic signed [COORD_WIDTH-1:0] v1_z;
    logic signed [COORD_WIDTH-1:0] v2_x;
    logic signed [COORD_WIDTH-1:0] v2_y;
    logic signed [COORD_WIDTH-1:0] v2_z;

    modport source (
        output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
        input  ready
    );
    modport sink (
        input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
        output ready
    );
endinterface

interface tpc_res_if;
    logic                valid;
    logic                ready;
    tpc_pkg::t_tri_class tri_class;
    tpc_pkg::t_side      v0_side;
    tpc_pkg::t_side      v1_side;
    tpc_pkg::t_side      v2_side;

    modport source (
        output valid, tri_class, v0_side, v1_side, v2_side,
        input  ready
    );
    modport sink (
        input  valid, tri_class, v0_side, v1_side, v2_side,
        output ready
    );
endinterface

// ===== design/tpc_cfg_regs.sv =====
// Plane configuration registers: normal, offset and on-plane tolerance.
// Depends on tpc_pkg for the register indexes and reset values.
`timescale 1ns / 1ps

module tpc_cfg_regs #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]             i_cfg_wdata,
    output logic signed [COORD_WIDTH-1:0]      o_normal_x,
    output logic signed [COORD_WIDTH-1:0]      o_normal_y,
    output logic signed [COORD_WIDTH-1:0]      o_normal_z,
    output logic signed [COORD_WIDTH-1:0]      o_offset,
    output logic [COORD_WIDTH-2:0]             o_epsilon
);

    logic signed [COORD_WIDTH-1:0] r_normal_x;
    logic signed [COORD_WIDTH-1:0] r_normal_y;
    logic signed [COORD_WIDTH-1:0] r_normal_z;
    logic signed [COORD_WIDTH-1:0] r_offset;
    logic [COORD_WIDTH-2:0]        r_epsilon;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_x <= '0;
            r_normal_y <= '0;
            r_normal_z <= '0;
            r_offset   <= '0;
            r_epsilon  <= (COORD_WIDTH-1)'(tpc_pkg::EPS_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tpc_pkg::CFG_NORMAL_X: r_normal_x <= i_cfg_wdata;
                tpc_pkg::CFG_NORMAL_Y: r_normal_y <= i_cfg_wdata;
                tpc_pkg::CFG_NORMAL_Z: r_normal_z <= i_cfg_wdata;
                tpc_pkg::CFG_OFFSET:   r_offset   <= i_cfg_wdata;
                tpc_pkg::CFG_EPSILON:  r_epsilon  <= i_cfg_wdata[COORD_WIDTH-2:0];
                default: ;
            endcase
        end
    end

    assign o_normal_x = r_normal_x;
    assign o_normal_y = r_normal_y;
    assign o_normal_z = r_normal_z;
    assign o_offset   = r_offset;
    assign o_epsilon  = r_epsilon;

endmodule

// ===== design/tpc_lane.sv =====
// One vertex lane: three signed products in the first stage, exact
// signed distance a*x+b*y+c*z+d*2^16 in the second stage.
// Depends on tpc_pkg for the stage control struct and QFRAC.
`timescale 1ns / 1ps

module tpc_lane #(
    parameter int COORD_WIDTH = 32,
    parameter int DIST_WIDTH  = 2 * COORD_WIDTH + 2
) (
    input  logic                             i_clk,
    input  tpc_pkg::t_pipe_ctl               i_ctl,
    input  logic signed [COORD_WIDTH-1:0]    i_normal_x,
    input  logic signed [COORD_WIDTH-1:0]    i_normal_y,
    input  logic signed [COORD_WIDTH-1:0]    i_normal_z,
    input  logic signed [COORD_WIDTH-1:0]    i_offset,
    input  logic signed [COORD_WIDTH-1:0]    i_x,
    input  logic signed [COORD_WIDTH-1:0]    i_y,
    input  logic signed [COORD_WIDTH-1:0]    i_z,
    output logic signed [DIST_WIDTH-1:0]     o_dist
);

    localparam int PW = 2 * COORD_WIDTH;
    localparam int OW = COORD_WIDTH + tpc_pkg::QFRAC;

    logic signed [PW-1:0]         r_px, r_py, r_pz;
    logic signed [PW-1:0]         n_px, n_py, n_pz;
    logic signed [OW-1:0]         r_pd;
    logic signed [DIST_WIDTH-1:0] r_dist, n_dist;

    // full-width products, Q32.32
    assign n_px = i_normal_x * i_x;
    assign n_py = i_normal_y * i_y;
    assign n_pz = i_normal_z * i_z;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
            r_pd <= {i_offset, {tpc_pkg::QFRAC{1'b0}}};
        end
    end

    // exact sum, wide enough that it never overflows
    assign n_dist = DIST_WIDTH'(r_px) + DIST_WIDTH'(r_py)
                  + DIST_WIDTH'(r_pz) + DIST_WIDTH'(r_pd);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_dist <= n_dist;
        end
    end

    assign o_dist = r_dist;

endmodule

// ===== design/triangle_plane_classify.sv =====
// Triangle versus plane classifier, top level: input register, three
// vertex lanes, side compare and class combine into the result register.
// Depends on tpc_pkg, tpc_if, tpc_cfg_regs and tpc_lane.
//
//   port          dir  what moves
//   i_tri         in   one triangle, nine signed Q16.16 coordinates
//   o_res         out  triangle class and three vertex sides
//   i_cfg_*       in   plane register writes (index, data)
//
// One triangle per cycle sustained while the result side accepts; a result
// passes through the input register, product stage, sum stage and result
// register, on the multiply then add path of each vertex lane.
// Each stage loads when it is empty or its successor moves, so bubbles
// are squeezed out while the result side stalls.
// Synchronous active-low reset empties the pipeline and loads the plane
// registers with zero normal, zero offset and the default tolerance.
`timescale 1ns / 1ps

module triangle_plane_classify #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tpc_tri_if.sink                         i_tri,
    tpc_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]          i_cfg_wdata
);

    localparam int DW = 2 * COORD_WIDTH + 2;
    localparam int NV = tpc_pkg::VERTEX_COUNT;

    logic signed [COORD_WIDTH-1:0] w_normal_x, w_normal_y, w_normal_z, w_offset;
    logic [COORD_WIDTH-2:0]        w_epsilon;

    // plane registers
    tpc_cfg_regs #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_normal_x  (w_normal_x),
        .o_normal_y  (w_normal_y),
        .o_normal_z  (w_normal_z),
        .o_offset    (w_offset),
        .o_epsilon   (w_epsilon)
    );

    // stage valid flags and load enables
    logic r_v_in, r_v_mul, r_v_sum, r_v_out;
    logic w_en_in, w_en_mul, w_en_sum, w_en_out;
    tpc_pkg::t_pipe_ctl w_ctl;

    assign w_en_out  = !r_v_out || o_res.ready;
    assign w_en_sum  = !r_v_sum || w_en_out;
    assign w_en_mul  = !r_v_mul || w_en_sum;
    assign w_en_in   = !r_v_in  || w_en_mul;
    assign i_tri.ready = w_en_in;

    assign w_ctl.en_mul = w_en_mul;
    assign w_ctl.en_sum = w_en_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in  <= 1'b0;
            r_v_mul <= 1'b0;
            r_v_sum <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            if (w_en_in)  r_v_in  <= i_tri.valid;
            if (w_en_mul) r_v_mul <= r_v_in;
            if (w_en_sum) r_v_sum <= r_v_mul;
            if (w_en_out) r_v_out <= r_v_sum;
        end
    end

    // input register, one row of coordinates per vertex
    logic signed [COORD_WIDTH-1:0] r_x [NV];
    logic signed [COORD_WIDTH-1:0] r_y [NV];
    logic signed [COORD_WIDTH-1:0] r_z [NV];

    always_ff @(posedge i_clk) begin
        if (w_en_in) begin
            r_x[0] <= i_tri.v0_x;
            r_y[0] <= i_tri.v0_y;
            r_z[0] <= i_tri.v0_z;
            r_x[1] <= i_tri.v1_x;
            r_y[1] <= i_tri.v1_y;
            r_z[1] <= i_tri.v1_z;
            r_x[2] <= i_tri.v2_x;
            r_y[2] <= i_tri.v2_y;
            r_z[2] <= i_tri.v2_z;
        end
    end

    // tolerance scaled to the distance format
    logic signed [DW-1:0] w_thr_pos, w_thr_neg;
    assign w_thr_pos = DW'({w_epsilon, {tpc_pkg::QFRAC{1'b0}}});
    assign w_thr_neg = -w_thr_pos;

    logic signed [DW-1:0] w_dist [NV];
    tpc_pkg::t_side       n_side [NV];
    logic [NV-1:0]        w_front, w_back, w_on;

    // vertex lanes and side compare
    for (genvar g = 0; g < NV; g++) begin : g_lane
        tpc_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .DIST_WIDTH  (DW)
        ) u_lane (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_normal_x (w_normal_x),
            .i_normal_y (w_normal_y),
            .i_normal_z (w_normal_z),
            .i_offset   (w_offset),
            .i_x        (r_x[g]),
            .i_y        (r_y[g]),
            .i_z        (r_z[g]),
            .o_dist     (w_dist[g])
        );

        always_comb begin
            if (w_dist[g] > w_thr_pos) begin
                n_side[g] = tpc_pkg::SIDE_FRONT;
            end else if (w_dist[g] < w_thr_neg) begin
                n_side[g] = tpc_pkg::SIDE_BACK;
            end else begin
                n_side[g] = tpc_pkg::SIDE_ON;
            end
        end

        assign w_front[g] = (n_side[g] == tpc_pkg::SIDE_FRONT);
        assign w_back[g]  = (n_side[g] == tpc_pkg::SIDE_BACK);
        assign w_on[g]    = (n_side[g] == tpc_pkg::SIDE_ON);
    end

    // whole-triangle class
    tpc_pkg::t_tri_class n_class;
    always_comb begin
        if (&w_on) begin
            n_class = tpc_pkg::CLASS_ON;
        end else if (!(|w_back)) begin
            n_class = tpc_pkg::CLASS_FRONT;
        end else if (!(|w_front)) begin
            n_class = tpc_pkg::CLASS_BACK;
        end else begin
            n_class = tpc_pkg::CLASS_CLIPPED;
        end
    end

    // result register
    tpc_pkg::t_tri_class r_class;
    tpc_pkg::t_side      r_side [NV];

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_class   <= n_class;
            r_side[0] <= n_side[0];
            r_side[1] <= n_side[1];
            r_side[2] <= n_side[2];
        end
    end

    assign o_res.valid     = r_v_out;
    assign o_res.tri_class = r_class;
    assign o_res.v0_side   = r_side[0];
    assign o_res.v1_side   = r_side[1];
    assign o_res.v2_side   = r_side[2];

`ifndef NO_ASSERTIONS
    // input held off only when every stage is full and the result stalls
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tri.ready |-> (r_v_in && r_v_mul && r_v_sum && r_v_out && !o_res.ready))
        else $error("input stalled with room in the pipeline");

    // an on-plane triangle has every vertex on the plane
    a_on_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.tri_class == tpc_pkg::CLASS_ON) |->
        (o_res.v0_side == tpc_pkg::SIDE_ON && o_res.v1_side == tpc_pkg::SIDE_ON
         && o_res.v2_side == tpc_pkg::SIDE_ON))
        else $error("on-plane class with a vertex off the plane");

    // a front triangle has no back vertex
    a_front_noback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.tri_class == tpc_pkg::CLASS_FRONT) |->
        (o_res.v0_side != tpc_pkg::SIDE_BACK && o_res.v1_side != tpc_pkg::SIDE_BACK
         && o_res.v2_side != tpc_pkg::SIDE_BACK))
        else $error("front class with a back vertex");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_res.valid && !r_v_in && !r_v_mul && !r_v_sum))
        else $error("pipeline not empty after reset");
`endif

endmodule
